// File: src/bmd_pkg.sv
package bmd_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int LINE_DEPTH   = MAX_WIDTH / 2;
   localparam int LINE_AW      = $clog2(LINE_DEPTH);
   localparam int HEIGHT_LIMIT = 2048;

   localparam int CHAN_W  = 8;
   localparam int PAIR_W  = 10;
   localparam int COUNT_W = 11;
   localparam int CFG_W   = 12;

   localparam int CSR_INDEX_W = 2;
   localparam int PIXEL_W     = 4 * CHAN_W;
   localparam int LINE_W      = 4 * PAIR_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RGB_MODE     = 2'd2;

   // Horizontal pair sum of one column pair, red in the lowest bits.
   typedef struct packed {
      logic [PAIR_W-1:0] alpha;
      logic [PAIR_W-1:0] blue;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] red;
   } pair_sum_type;

endpackage

// File: src/bmd_line_ram.sv
module bmd_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/box_filter_mip_downsample.sv
// An odd-row, odd-column pixel transfer passes through the A stage register and the
// output register to rsp_tvalid; other pixels produce no output.
// Throughput: one source pixel per cycle unless the output stalls; the line store takes
// one write or one read per cycle (even rows write, odd rows read), so no port conflict.
// Reset is synchronous: counters, held pixel, mode and valids clear, sizes go to minimum;
// the line store is not cleared and holds garbage until an even row writes it.
module box_filter_mip_downsample (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // red_in, green_in, blue_in, alpha_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,  // red_out, green_out, blue_out, alpha_out
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [bmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bmd_pkg::CFG_W-1:0]          csr_wdata
);
   import bmd_pkg::*;

   localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(HEIGHT_LIMIT);
   localparam logic [CFG_W-1:0] SIZE_MIN     = CFG_W'(2);

   logic [CFG_W-1:0]   image_width_ff, image_height_ff;
   logic               rgb_mode_ff;
   logic [PIXEL_W-1:0] held_pixel_ff;
   logic [COUNT_W-1:0] column_count_ff, column_count_in;
   logic [COUNT_W-1:0] row_count_ff, row_count_in;
   pair_sum_type       pair_ff;
   logic               a_valid_ff, a_valid_in;
   logic               a_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;

   logic               accept, out_free, a_move;
   logic [CFG_W-1:0]   width_last, height_last;
   logic               end_col, end_row, odd_col, odd_row;
   logic [PIXEL_W-1:0] pix;
   pair_sum_type       pair;
   pair_sum_type       above;
   logic [LINE_W-1:0]  above_raw;
   logic [LINE_AW-1:0] line_addr;
   logic [PAIR_W:0]    sum_r, sum_g, sum_b, sum_a;

   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] limit);
      logic [CFG_W-1:0] e;
      e = {v[CFG_W-1:1], 1'b0};
      if (e < SIZE_MIN) begin
         e = SIZE_MIN;
      end
      if (e > limit) begin
         e = limit;
      end
      return e;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign a_move     = a_valid_ff && out_free;
   assign req_tready = !a_valid_ff || a_move;
   assign accept     = req_tvalid && req_tready;

   assign pix         = req_tdata;
   assign width_last  = eff_size(image_width_ff, WIDTH_LIMIT) - CFG_W'(1);
   assign height_last = eff_size(image_height_ff, HEIGHT_MAX) - CFG_W'(1);
   assign end_col     = {1'b0, column_count_ff} >= width_last;
   assign end_row     = {1'b0, row_count_ff} >= height_last;
   assign odd_col     = column_count_ff[0];
   assign odd_row     = row_count_ff[0];
   assign line_addr   = column_count_ff[LINE_AW:1];

   assign pair.red   = PAIR_W'(held_pixel_ff[7:0])   + PAIR_W'(pix[7:0]);
   assign pair.green = PAIR_W'(held_pixel_ff[15:8])  + PAIR_W'(pix[15:8]);
   assign pair.blue  = PAIR_W'(held_pixel_ff[23:16]) + PAIR_W'(pix[23:16]);
   assign pair.alpha = PAIR_W'(held_pixel_ff[31:24]) + PAIR_W'(pix[31:24]);

   bmd_line_ram #(
      .DEPTH (LINE_DEPTH),
      .WIDTH (LINE_W)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept && odd_col && !odd_row),
      .wr_addr (line_addr),
      .wr_data (pair),
      .rd_en   (accept && odd_col && odd_row),
      .rd_addr (line_addr),
      .rd_data (above_raw)
   );

   assign above = above_raw;

   // Vertical add of the stored pair sum and this row's pair sum.
   assign sum_r = (PAIR_W+1)'(above.red)   + (PAIR_W+1)'(pair_ff.red);
   assign sum_g = (PAIR_W+1)'(above.green) + (PAIR_W+1)'(pair_ff.green);
   assign sum_b = (PAIR_W+1)'(above.blue)  + (PAIR_W+1)'(pair_ff.blue);
   assign sum_a = (PAIR_W+1)'(above.alpha) + (PAIR_W+1)'(pair_ff.alpha);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (end_col) begin
            column_count_in = '0;
            row_count_in    = end_row ? '0 : row_count_ff + COUNT_W'(1);
         end else begin
            column_count_in = column_count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff && !a_move;
      if (accept && odd_col && odd_row) begin
         a_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (a_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_MIN;
         image_height_ff <= SIZE_MIN;
         rgb_mode_ff     <= 1'b0;
         held_pixel_ff   <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         a_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               CSR_RGB_MODE:     rgb_mode_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept && !odd_col) begin
            held_pixel_ff <= pix;
         end
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         a_valid_ff      <= a_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && odd_col && odd_row) begin
         pair_ff   <= pair;
         a_last_ff <= end_col && end_row;
      end
      if (a_move) begin
         rsp_data_ff <= {rgb_mode_ff ? 8'hFF : sum_a[PAIR_W-1:2], sum_b[PAIR_W-1:2],
                         sum_g[PAIR_W-1:2], sum_r[PAIR_W-1:2]};
         rsp_last_ff <= a_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: src/bmd_checker.sv
module bmd_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic rsp_tlast
);

   // A stalled output pixel must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output pixel changed while stalled");

   // The input side only stalls when the output register is full and blocked.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // A new output pixel follows a source pixel transfer through the A stage and the output register.
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("output pixel appeared without a source transfer");

   // Reset leaves no pixel pending on the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind box_filter_mip_downsample bmd_checker u_bmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
